// ===== src/cbiam_pkg.sv =====
`timescale 1ns / 1ps

package cbiam_pkg;

  localparam int ATTR_ENTRIES = 1024;
  localparam int ATTR_OFF_W   = $clog2(ATTR_ENTRIES);
  localparam int ATTR_AW      = ATTR_OFF_W + 1;
  localparam int ATTR_DEPTH   = 2 * ATTR_ENTRIES;

  localparam int CMD_W      = 3;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_CPU_WR   = 3'd0,
    CMD_CPU_RD   = 3'd1,
    CMD_PIC_RD   = 3'd2,
    CMD_TICK     = 3'd3,
    CMD_SOFT_RST = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH
  } state_t;

  // mapper register select, addr bits 3:0
  localparam logic [3:0] REG_IRQ_LATCH = 4'h8;
  localparam logic [3:0] REG_IRQ_CTRL  = 4'h9;
  localparam logic [3:0] REG_CONTROL   = 4'hA;
  localparam logic [3:0] REG_PRG       = 4'hB;
  // pattern bank registers, addr bits 3:2
  localparam logic [1:0] REG_CHR_SEL   = 2'b11;

  localparam logic [1:0] MIR_VERT = 2'd0;
  localparam logic [1:0] MIR_HORZ = 2'd1;
  localparam logic [1:0] MIR_LOW  = 2'd2;
  localparam logic [1:0] MIR_HIGH = 2'd3;

  localparam logic [1:0]  REGION_MAPPER = 2'b10;
  localparam logic [1:0]  REGION_ATTR   = 2'b11;
  localparam logic [4:0]  JUMPER_PAGE   = 5'b01001;
  localparam logic [6:0]  JUMPER_ID     = 7'h64;
  localparam logic [15:0] PIC_LO        = 16'h2000;
  localparam logic [15:0] PIC_HI        = 16'h3F00;
  localparam logic [ATTR_OFF_W-1:0] ATTR_TABLE_BASE = ATTR_OFF_W'(10'h3C0);

  typedef struct packed {
    logic accept;
    logic out_load_now;
    logic out_load_mem;
    logic clr_run;
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
    logic needs_mem;
    logic soft_rst;
    logic clr_last;
  } dp_stat_t;

  // attribute copied into all four quadrants
  function automatic logic [7:0] attr_fill(input logic [1:0] a);
    return {4{a}};
  endfunction

endpackage

// ===== src/cbiam_ctrl.sv =====
`timescale 1ns / 1ps

module cbiam_ctrl
  import cbiam_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     out_tready,
  input  dp_stat_t stat,
  output logic     in_tready,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_run = 1'b1;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        // output slot free, or its item leaves this cycle
        in_tready = !stat.out_full || out_tready;
        if (in_tvalid && in_tready) begin
          cmd.accept = 1'b1;
          priority if (stat.needs_mem) begin
            state_nxt = ST_FETCH;
          end else begin
            cmd.out_load_now = 1'b1;
            if (stat.soft_rst) state_nxt = ST_CLEAR;
          end
        end
      end
      ST_FETCH: begin
        cmd.out_load_mem = 1'b1;
        state_nxt        = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> (!stat.out_full || out_tready))
    else $error("item accepted with no room in output register");
  a_fetch_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && stat.needs_mem) |=> cmd.out_load_mem)
    else $error("attribute fetch not completed next cycle");
  a_soft_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && stat.soft_rst) |=> (cmd.clr_run && !in_tready))
    else $error("soft reset did not start clearing pass");
`endif

endmodule

// ===== src/cbiam_dp.sv =====
`timescale 1ns / 1ps

module cbiam_dp
  import cbiam_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic [CMD_W-1:0]      in_tuser,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic [1:0] attr_mem [ATTR_DEPTH];

  logic [3:0]            ctl_r, ctl_nxt;
  logic [3:0]            prg_r, prg_nxt;
  logic [3:0]            chr_r [4];
  logic [3:0]            chr_nxt [4];
  logic                  irq_en_r, irq_en_nxt;
  logic [7:0]            irq_latch_r, irq_latch_nxt;
  logic [15:0]           irq_cnt_r, irq_cnt_nxt;
  logic                  irq_pend_r, irq_pend_nxt;
  logic [ATTR_OFF_W-1:0] last_off_r, last_off_nxt;
  logic                  jumper_r, jumper_nxt;
  logic [ATTR_AW-1:0]    clr_addr_r;
  logic [1:0]            attr_q_r;
  logic                  out_valid_r;
  logic [7:0]            out_rdata_r;
  logic                  out_rvalid_r;

  cmd_t                  op;
  logic [15:0]           addr;
  logic [7:0]            wdata;
  logic [7:0]            cycles;
  logic [ATTR_OFF_W-1:0] off;
  logic                  pic_hit;
  logic                  name_rd;
  logic                  bank;
  logic [16:0]           cnt_dif;
  logic                  jumper_hit;
  logic                  mem_we;
  logic [ATTR_AW-1:0]    mem_wa;
  logic [1:0]            mem_wd;
  logic [ATTR_AW-1:0]    mem_ra;

  assign op     = cmd_t'(in_tuser);
  assign addr   = in_tdata[15:0];
  assign wdata  = in_tdata[23:16];
  assign cycles = in_tdata[31:24];
  assign off    = addr[ATTR_OFF_W-1:0];

  assign pic_hit    = (op == CMD_PIC_RD) && (addr > PIC_LO) && (addr < PIC_HI) && ctl_r[2];
  assign name_rd    = pic_hit && (off < ATTR_TABLE_BASE);
  assign jumper_hit = (op == CMD_CPU_RD) && (addr[15:11] == JUMPER_PAGE);
  assign cnt_dif    = {irq_cnt_r[15], irq_cnt_r} - {9'd0, cycles};

  always_comb begin
    unique case (ctl_r[1:0])
      MIR_VERT: bank = addr[11];
      MIR_HORZ: bank = addr[10];
      MIR_LOW:  bank = 1'b0;
      MIR_HIGH: bank = 1'b1;
      default:  bank = 1'b0;
    endcase
  end

  assign mem_ra = {bank, last_off_r};
  assign mem_we = cmd.clr_run ||
                  (cmd.accept && (op == CMD_CPU_WR) && (addr[15:14] == REGION_ATTR));
  assign mem_wa = cmd.clr_run ? clr_addr_r : addr[ATTR_AW-1:0];
  assign mem_wd = cmd.clr_run ? 2'b00 : wdata[1:0];

  assign stat.out_full  = out_valid_r;
  assign stat.needs_mem = pic_hit && !name_rd;
  assign stat.soft_rst  = (op == CMD_SOFT_RST);
  assign stat.clr_last  = (clr_addr_r == ATTR_AW'(ATTR_DEPTH - 1));

  always_comb begin
    ctl_nxt       = ctl_r;
    prg_nxt       = prg_r;
    chr_nxt       = chr_r;
    irq_en_nxt    = irq_en_r;
    irq_latch_nxt = irq_latch_r;
    irq_cnt_nxt   = irq_cnt_r;
    irq_pend_nxt  = irq_pend_r;
    last_off_nxt  = last_off_r;
    jumper_nxt    = jumper_r;
    if (cmd.accept) begin
      unique case (op)
        CMD_CPU_WR: begin
          if (addr[15:14] == REGION_MAPPER) begin
            priority if (addr[3:0] == REG_IRQ_LATCH) begin
              irq_latch_nxt = wdata;
            end else if (addr[3:0] == REG_IRQ_CTRL) begin
              irq_cnt_nxt  = {1'b0, wdata[6:0], irq_latch_r};
              irq_en_nxt   = wdata[7];
              irq_pend_nxt = 1'b0;
            end else if (addr[3:0] == REG_CONTROL) begin
              ctl_nxt = wdata[3:0];
            end else if (addr[3:0] == REG_PRG) begin
              prg_nxt = wdata[3:0];
            end else if (addr[3:2] == REG_CHR_SEL) begin
              chr_nxt[addr[1:0]] = wdata[3:0];
            end else begin
              // sound registers, ignored
            end
          end
        end
        CMD_PIC_RD: begin
          if (name_rd) last_off_nxt = off;
        end
        CMD_TICK: begin
          if (irq_en_r) begin
            irq_cnt_nxt = cnt_dif[15:0];
            // count reached zero or went negative
            if (cnt_dif[16] || (cnt_dif == 17'd0)) begin
              irq_en_nxt   = 1'b0;
              irq_pend_nxt = 1'b1;
            end
          end
        end
        CMD_SOFT_RST: begin
          ctl_nxt    = '0;
          prg_nxt    = '0;
          chr_nxt[0] = 4'd0;
          chr_nxt[1] = 4'd1;
          chr_nxt[2] = 4'd2;
          chr_nxt[3] = 4'd3;
          jumper_nxt = !jumper_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r       <= '0;
      prg_r       <= '0;
      chr_r[0]    <= 4'd0;
      chr_r[1]    <= 4'd1;
      chr_r[2]    <= 4'd2;
      chr_r[3]    <= 4'd3;
      irq_en_r    <= 1'b0;
      irq_latch_r <= '0;
      irq_cnt_r   <= '0;
      irq_pend_r  <= 1'b0;
      last_off_r  <= '0;
      jumper_r    <= 1'b0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ctl_r       <= ctl_nxt;
      prg_r       <= prg_nxt;
      chr_r       <= chr_nxt;
      irq_en_r    <= irq_en_nxt;
      irq_latch_r <= irq_latch_nxt;
      irq_cnt_r   <= irq_cnt_nxt;
      irq_pend_r  <= irq_pend_nxt;
      last_off_r  <= last_off_nxt;
      jumper_r    <= jumper_nxt;
      // wraps back to zero after the last entry
      if (cmd.clr_run) clr_addr_r <= clr_addr_r + 1'b1;
      priority if (cmd.out_load_now || cmd.out_load_mem) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end else begin
        out_valid_r <= out_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load_mem) begin
      out_rdata_r  <= attr_fill(attr_q_r);
      out_rvalid_r <= 1'b1;
    end else if (cmd.out_load_now) begin
      out_rdata_r  <= jumper_hit ? {jumper_r, JUMPER_ID} : 8'h00;
      out_rvalid_r <= jumper_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) attr_mem[mem_wa] <= mem_wd;
    attr_q_r <= attr_mem[mem_ra];
  end

  // bank and irq fields follow the live registers: they only move when the
  // next item is accepted, which is also when the held result leaves
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, ctl_r[3], ctl_r[1:0], chr_r[3], chr_r[2], chr_r[1], chr_r[0],
                       prg_r, irq_pend_r, out_rvalid_r, out_rdata_r};

`ifndef NO_ASSERTIONS
  a_mem_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load_mem |-> !out_valid_r)
    else $error("attribute result would overwrite a waiting item");
  a_mem_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load_mem |=> (out_valid_r && out_rvalid_r))
    else $error("attribute fetch result not marked valid");
  a_irq_fire: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(irq_pend_r) |-> !irq_en_r)
    else $error("irq raised while counter still enabled");
  a_clear_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.clr_run && stat.clr_last) |=> (clr_addr_r == '0))
    else $error("clear address did not wrap");
`endif

endmodule

// ===== src/cartridge_bank_irq_attr_mapper.sv =====
`timescale 1ns / 1ps

// channel  ports              tdata / tuser
// in       in_tvalid/tready   tuser: cmd; tdata: addr, wdata, cycles
// out      out_tvalid/tready  tdata: read_data .. wram_enable, zero padded
//
// one item per cycle while the output register has room, for every command but
// an attribute fetch, which waits in a fetch state for the registered read of
// the attribute memory and takes no new item there; after reset and after each
// soft reset a clearing pass writes all 2048 attribute entries, one a cycle,
// and no item is accepted during the pass; a result waits in the output
// register; a new item is taken in the cycle the waiting one leaves

module cartridge_bank_irq_attr_mapper
  import cbiam_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [CMD_W-1:0]      in_tuser,   // cmd
  input  logic [IN_DATA_W-1:0]  in_tdata,   // addr, wdata, cycles
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // read_data, read_valid, irq_line, prg_bank, chr_bank_a, chr_bank_b,
  // chr_bank_c, chr_bank_d, mirror_mode, wram_enable
  output logic [OUT_DATA_W-1:0] out_tdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  cbiam_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .in_tready  (in_tready),
    .cmd        (cmd)
  );

  cbiam_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import cbiam_pkg::*;

  localparam int RAND_ITEMS = 1030;

  // one result item, lowest field last
  typedef struct packed {
    logic       wram;
    logic [1:0] mirror;
    logic [3:0] chr_d;
    logic [3:0] chr_c;
    logic [3:0] chr_b;
    logic [3:0] chr_a;
    logic [3:0] prg;
    logic       irq;
    logic       rvalid;
    logic [7:0] rdata;
  } map_out_t;

  typedef struct {
    logic [2:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  wd;
    logic [7:0]  cy;
    bit          typed;
    map_out_t    res;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [CMD_W-1:0]      in_tuser = '0;      // cmd
  logic [IN_DATA_W-1:0]  in_tdata = '0;      // addr, wdata, cycles
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // read_data, read_valid, irq_line, prg_bank, chr_bank_a, chr_bank_b,
  // chr_bank_c, chr_bank_d, mirror_mode, wram_enable
  logic [OUT_DATA_W-1:0] out_tdata;

  cartridge_bank_irq_attr_mapper dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // mirrored mapper state
  logic [3:0]  m_ctrl;
  logic [3:0]  m_prg;
  logic [3:0]  m_chr [4];
  logic        m_irq_en;
  logic [7:0]  m_irq_latch;
  logic [15:0] m_irq_cnt;
  logic        m_irq_pend;
  logic [9:0]  m_last_off;
  logic        m_jumper;
  logic [1:0]  m_attr [ATTR_DEPTH];

  map_out_t    pending_responses [$];
  logic [9:0]  hot_off [8];
  int unsigned mismatch_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned fetch_cnt = 0;
  int unsigned soft_rst_cnt = 0;
  int unsigned irq_rise_cnt = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  task automatic clear_banks();
    m_ctrl = '0;
    m_prg  = '0;
    for (int k = 0; k < 4; k++) m_chr[k] = 4'(k);
    for (int k = 0; k < ATTR_DEPTH; k++) m_attr[k] = 2'b00;
  endtask

  task automatic predict_mapper_response(input logic [2:0] cmd, input logic [15:0] addr,
                                         input logic [7:0] wd, input logic [7:0] cy,
                                         output map_out_t r);
    int  c;
    logic bank;
    r = '0;
    case (cmd)
      CMD_CPU_WR: begin
        if (addr[15:14] == REGION_MAPPER) begin
          if (addr[3:0] == REG_IRQ_LATCH) begin
            m_irq_latch = wd;
          end else if (addr[3:0] == REG_IRQ_CTRL) begin
            m_irq_cnt  = {1'b0, wd[6:0], m_irq_latch};
            m_irq_en   = wd[7];
            m_irq_pend = 1'b0;
          end else if (addr[3:0] == REG_CONTROL) begin
            m_ctrl = wd[3:0];
          end else if (addr[3:0] == REG_PRG) begin
            m_prg = wd[3:0];
          end else if (addr[3:2] == 2'b11) begin
            m_chr[addr[1:0]] = wd[3:0];
          end
        end else if (addr[15:14] == REGION_ATTR) begin
          m_attr[{addr[10], addr[9:0]}] = wd[1:0];
        end
      end
      CMD_CPU_RD: begin
        if (addr[15:11] == JUMPER_PAGE) begin
          r.rdata  = {m_jumper, JUMPER_ID};
          r.rvalid = 1'b1;
        end
      end
      CMD_PIC_RD: begin
        if (addr > PIC_LO && addr < PIC_HI && m_ctrl[2]) begin
          if (addr[9:0] < ATTR_TABLE_BASE) begin
            m_last_off = addr[9:0];
          end else begin
            case (m_ctrl[1:0])
              MIR_VERT: bank = addr[11];
              MIR_HORZ: bank = addr[10];
              MIR_LOW:  bank = 1'b0;
              default:  bank = 1'b1;
            endcase
            case (m_attr[{bank, m_last_off}])
              2'd0:    r.rdata = 8'h00;
              2'd1:    r.rdata = 8'h55;
              2'd2:    r.rdata = 8'hAA;
              default: r.rdata = 8'hFF;
            endcase
            r.rvalid = 1'b1;
          end
        end
      end
      CMD_TICK: begin
        if (m_irq_en) begin
          c = int'($signed(m_irq_cnt)) - int'(cy);
          m_irq_cnt = 16'(c);
          if (c <= 0) begin
            m_irq_en   = 1'b0;
            m_irq_pend = 1'b1;
          end
        end
      end
      CMD_SOFT_RST: begin
        clear_banks();
        m_jumper = ~m_jumper;
      end
      default: ;
    endcase
    r.irq    = m_irq_pend;
    r.prg    = m_prg;
    r.chr_a  = m_chr[0];
    r.chr_b  = m_chr[1];
    r.chr_c  = m_chr[2];
    r.chr_d  = m_chr[3];
    r.mirror = m_ctrl[1:0];
    r.wram   = m_ctrl[3];
  endtask

  function automatic stim_row_t row(logic [2:0] cmd, logic [15:0] addr, logic [7:0] wd,
                                    logic [7:0] cy);
    stim_row_t r;
    r.cmd = cmd;
    r.addr = addr;
    r.wd = wd;
    r.cy = cy;
    r.typed = 1'b0;
    r.res = '0;
    return r;
  endfunction

  function automatic stim_row_t row_t(logic [2:0] cmd, logic [15:0] addr, logic [7:0] wd,
                                      logic [7:0] rdata, logic rvalid, logic irq,
                                      logic [3:0] prg, logic [3:0] a, logic [3:0] b,
                                      logic [3:0] c, logic [3:0] d, logic [1:0] mir,
                                      logic wram);
    stim_row_t r;
    r = row(cmd, addr, wd, 8'h00);
    r.typed = 1'b1;
    r.res = '{wram: wram, mirror: mir, chr_d: d, chr_c: c, chr_b: b, chr_a: a, prg: prg,
              irq: irq, rvalid: rvalid, rdata: rdata};
    return r;
  endfunction

  // mostly well-formed bus traffic, offsets drawn from a small hot set so that
  // nametable reads, store writes and attribute fetches meet each other
  function automatic stim_row_t rand_access();
    stim_row_t   r;
    int unsigned pick;
    int unsigned sel;
    logic [9:0]  off;
    r = row(CMD_CPU_WR, 16'($urandom), 8'($urandom), 8'($urandom));
    pick = $urandom_range(0, 99);
    off = ($urandom_range(0, 9) < 6) ? hot_off[$urandom_range(0, 7)]
                                      : 10'($urandom_range(0, 10'h3BF));
    if (pick < 30) begin
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        r.addr[3:0] = REG_CONTROL;
        r.wd[2] = ($urandom_range(0, 3) != 0);
      end else if (sel < 40) begin
        r.addr[3:0] = REG_IRQ_LATCH;
      end else if (sel < 55) begin
        r.addr[3:0] = REG_IRQ_CTRL;
        r.wd[7] = ($urandom_range(0, 9) < 7);
        // short counts so that ticks reach zero
        if ($urandom_range(0, 4) != 0) r.wd[6:0] = 7'($urandom_range(0, 2));
      end else if (sel < 65) begin
        r.addr[3:0] = REG_PRG;
      end else if (sel < 85) begin
        r.addr[3:2] = 2'b11;
      end
      r.addr[15:14] = REGION_MAPPER;
    end else if (pick < 45) begin
      r.addr[15:14] = REGION_ATTR;
      if ($urandom_range(0, 9) != 0) r.addr[9:0] = off;
    end else if (pick < 65) begin
      r.cmd = CMD_PIC_RD;
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
        r.addr[15:13] = 3'b001;
        r.addr[9:0] = off;
      end else if (sel < 8) begin
        r.addr[15:13] = 3'b001;
        r.addr[9:6] = 4'hF;
      end
    end else if (pick < 80) begin
      r.cmd = CMD_TICK;
      if ($urandom_range(0, 3) == 0) r.cy = 8'($urandom_range(0, 3));
    end else if (pick < 92) begin
      r.cmd = CMD_CPU_RD;
      if ($urandom_range(0, 9) < 6) r.addr[15:11] = JUMPER_PAGE;
    end else if (pick < 96) begin
      r.cmd = CMD_CPU_WR;
    end else if (pick < 98) begin
      r.cmd = CMD_SOFT_RST;
    end else begin
      r.cmd = 3'($urandom_range(5, 7));
    end
    return r;
  endfunction

  initial begin
    stim_row_t   dir_tbl [$];
    stim_row_t   cur;
    map_out_t    pred;
    int unsigned burst_left;
    int unsigned gap;
    logic        irq_was;

    m_irq_en = 1'b0;
    m_irq_latch = '0;
    m_irq_cnt = '0;
    m_irq_pend = 1'b0;
    m_last_off = '0;
    m_jumper = 1'b0;
    clear_banks();
    for (int k = 0; k < 8; k++) hot_off[k] = 10'($urandom_range(0, 10'h3BF));

    dir_tbl.push_back(row_t(CMD_CPU_RD, 16'h4800, 8'h00, 8'h64, 1, 0, 0, 0, 1, 2, 3, 0, 0));
    dir_tbl.push_back(row_t(CMD_CPU_RD, 16'h4FFF, 8'h00, 8'h64, 1, 0, 0, 0, 1, 2, 3, 0, 0));
    dir_tbl.push_back(row_t(CMD_CPU_RD, 16'h5000, 8'h00, 8'h00, 0, 0, 0, 0, 1, 2, 3, 0, 0));
    dir_tbl.push_back(row_t(CMD_CPU_WR, 16'h800B, 8'hFF, 8'h00, 0, 0, 15, 0, 1, 2, 3, 0, 0));
    dir_tbl.push_back(row_t(CMD_CPU_WR, 16'hBFFF, 8'hFF, 8'h00, 0, 0, 15, 0, 1, 2, 15, 0, 0));
    dir_tbl.push_back(row(CMD_CPU_WR, 16'hA00C, 8'h5A, 8'h00));
    dir_tbl.push_back(row(CMD_CPU_WR, 16'h8000, 8'hFF, 8'h00));   // sound register
    dir_tbl.push_back(row(CMD_CPU_WR, 16'hC000, 8'hFF, 8'h00));
    dir_tbl.push_back(row(CMD_CPU_WR, 16'hE7BF, 8'h01, 8'h00));
    dir_tbl.push_back(row(CMD_CPU_WR, 16'h800A, 8'h07, 8'h00));
    dir_tbl.push_back(row(CMD_PIC_RD, 16'h2000, 8'h00, 8'h00));   // lower bound excluded
    dir_tbl.push_back(row(CMD_PIC_RD, 16'h23C0, 8'h00, 8'h00));
    dir_tbl.push_back(row(CMD_CPU_WR, 16'h800A, 8'h06, 8'h00));
    dir_tbl.push_back(row(CMD_PIC_RD, 16'h23C0, 8'h00, 8'h00));
    dir_tbl.push_back(row(CMD_PIC_RD, 16'h27BF, 8'h00, 8'h00));
    dir_tbl.push_back(row(CMD_CPU_WR, 16'h800A, 8'h0D, 8'h00));
    dir_tbl.push_back(row(CMD_PIC_RD, 16'h27FF, 8'h00, 8'h00));
    dir_tbl.push_back(row(CMD_PIC_RD, 16'h3F00, 8'h00, 8'h00));
    dir_tbl.push_back(row(CMD_CPU_WR, 16'h8008, 8'h10, 8'h00));
    dir_tbl.push_back(row(CMD_CPU_WR, 16'h8009, 8'h80, 8'h00));
    dir_tbl.push_back(row(CMD_TICK,   16'h0000, 8'h00, 8'h0F));
    dir_tbl.push_back(row(CMD_TICK,   16'h0000, 8'h00, 8'h01));   // count hits zero
    dir_tbl.push_back(row(CMD_CPU_WR, 16'h8009, 8'h00, 8'h00));
    dir_tbl.push_back(row(CMD_CPU_WR, 16'h8008, 8'h00, 8'h00));
    dir_tbl.push_back(row(CMD_CPU_WR, 16'h8009, 8'h80, 8'h00));
    dir_tbl.push_back(row(CMD_TICK,   16'h0000, 8'h00, 8'h00));   // zero count, zero tick
    dir_tbl.push_back(row(3'd7,       16'hFFFF, 8'hFF, 8'hFF));   // unused command
    dir_tbl.push_back(row(CMD_SOFT_RST, 16'h0000, 8'h00, 8'h00));
    dir_tbl.push_back(row_t(CMD_CPU_RD, 16'h4FFF, 8'h00, 8'hE4, 1, 1, 0, 0, 1, 2, 3, 0, 0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    burst_left = $urandom_range(1, 40);

    for (int i = 0; i < dir_tbl.size() + RAND_ITEMS; i++) begin
      cur = (i < dir_tbl.size()) ? dir_tbl[i] : rand_access();
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 40);
      end
      in_tvalid <= 1'b1;
      in_tuser  <= cur.cmd;
      in_tdata  <= {cur.cy, cur.wd, cur.addr};
      do @(posedge clk); while (!in_tready);
      irq_was = m_irq_pend;
      predict_mapper_response(cur.cmd, cur.addr, cur.wd, cur.cy, pred);
      if (cur.cmd == CMD_SOFT_RST) soft_rst_cnt++;
      if (cur.cmd == CMD_PIC_RD && pred.rvalid) fetch_cnt++;
      if (!irq_was && m_irq_pend) irq_rise_cnt++;
      pending_responses.push_back(cur.typed ? cur.res : pred);
      burst_left--;
    end
    in_tvalid <= 1'b0;

    wait (pending_responses.size() == 0);
    repeat (20) @(posedge clk);
    $display("%0d items sent, %0d results checked, %0d soft resets", dir_tbl.size() + RAND_ITEMS,
             checked_cnt, soft_rst_cnt);
    $display("%0d attribute fetches answered, %0d irq assertions", fetch_cnt, irq_rise_cnt);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // receiver stalls in randomly chosen modes, each held for a random run
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 128);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= ($urandom_range(0, 7) == 0);
      default: out_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic cmp_field(input string name, input int unsigned exp_v, input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk) begin
    map_out_t exp_r;
    map_out_t act_r;
    if (rst_n && out_tvalid && out_tready) begin
      act_r = out_tdata[32:0];
      if (pending_responses.size() == 0) begin
        $error("result item with no expectation: 0x%0h", out_tdata);
        mismatch_cnt++;
      end else begin
        exp_r = pending_responses.pop_front();
        checked_cnt++;
        cmp_field("read_data",   exp_r.rdata,  act_r.rdata);
        cmp_field("read_valid",  exp_r.rvalid, act_r.rvalid);
        cmp_field("irq_line",    exp_r.irq,    act_r.irq);
        cmp_field("prg_bank",    exp_r.prg,    act_r.prg);
        cmp_field("chr_bank_a",  exp_r.chr_a,  act_r.chr_a);
        cmp_field("chr_bank_b",  exp_r.chr_b,  act_r.chr_b);
        cmp_field("chr_bank_c",  exp_r.chr_c,  act_r.chr_c);
        cmp_field("chr_bank_d",  exp_r.chr_d,  act_r.chr_d);
        cmp_field("mirror_mode", exp_r.mirror, act_r.mirror);
        cmp_field("wram_enable", exp_r.wram,   act_r.wram);
        cmp_field("tdata_pad",   0,            out_tdata[OUT_DATA_W-1:33]);
      end
    end
  end

  // clearing passes after every soft reset dominate the run time
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
